>>> hdl/quadrature_detent_value_tracker_assert.svh
// Assertion macros for the quadrature detent value tracker.
// Included by the modules that check their own logic; needs nothing else.
`ifndef QUADRATURE_DETENT_VALUE_TRACKER_ASSERT_SVH
`define QUADRATURE_DETENT_VALUE_TRACKER_ASSERT_SVH

// same-cycle implication
`define QDVT_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("qdvt: check failed");

// next-cycle implication
`define QDVT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("qdvt: check failed");

`endif

>>> hdl/qdvt_pkg.sv
// Types and constants of the quadrature detent value tracker.
// Used by qdvt_update and the top level; depends on nothing.
package qdvt_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STEP_W  = 31;
   localparam int unsigned ACC_W   = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE   = 2'd2;

   localparam logic signed [VALUE_W-1:0] LOWER_LIMIT_RST = 32'sd0;
   localparam logic signed [VALUE_W-1:0] UPPER_LIMIT_RST = 32'sd6553600;
   localparam logic [STEP_W-1:0]         STEP_SIZE_RST   = 31'd65536;

   localparam logic [1:0] EVT_NONE = 2'd0;
   localparam logic [1:0] EVT_UP   = 2'd1;
   localparam logic [1:0] EVT_DOWN = 2'd2;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_LOAD   = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic                      pin_a;
      logic                      pin_b;
      logic signed [VALUE_W-1:0] load_value;
   } qdvt_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] current_value;
      logic [1:0]                detent_event;
      logic                      invalid_move;
   } qdvt_rsp_type;

   typedef struct packed {
      logic [1:0]                last_pins;
      logic                      primed;
      logic signed [ACC_W-1:0]   acc;
      logic signed [VALUE_W-1:0] value;
   } qdvt_state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] lower_limit;
      logic signed [VALUE_W-1:0] upper_limit;
      logic [STEP_W-1:0]         step_size;
   } qdvt_cfg_type;

endpackage

>>> hdl/qdvt_update.sv
// Next-state and result logic for one word of the detent value tracker.
// Pure combinational; depends on qdvt_pkg.
module qdvt_update #(
   parameter int unsigned MOVES_PER_DETENT = 4
) (
   input  qdvt_pkg::qdvt_req_type   item,
   input  qdvt_pkg::qdvt_state_type state,
   input  qdvt_pkg::qdvt_cfg_type   cfg,
   output qdvt_pkg::qdvt_state_type state_nxt,
   output qdvt_pkg::qdvt_rsp_type   result
);
   import qdvt_pkg::*;

   localparam int unsigned EXT_W = VALUE_W + 2;
   localparam logic signed [ACC_W-1:0] DET_POS = ACC_W'(MOVES_PER_DETENT);
   localparam logic signed [ACC_W-1:0] DET_NEG = -DET_POS;

   logic signed [VALUE_W-1:0] lo;
   logic signed [VALUE_W-1:0] hi;
   logic signed [VALUE_W-1:0] cur;
   logic signed [EXT_W-1:0]   cur_ext;
   logic signed [EXT_W-1:0]   step_ext;
   logic signed [EXT_W-1:0]   sum_up;
   logic signed [EXT_W-1:0]   sum_dn;
   logic [1:0]                pins;
   logic [1:0]                pos_new;
   logic [1:0]                pos_old;
   logic [1:0]                pos_diff;
   logic signed [ACC_W-1:0]   acc_step;

   function automatic logic signed [VALUE_W-1:0] clamp(
      input logic signed [EXT_W-1:0]   v,
      input logic signed [VALUE_W-1:0] lim_lo,
      input logic signed [VALUE_W-1:0] lim_hi
   );
      logic signed [VALUE_W-1:0] r;
      if (v > EXT_W'(lim_hi)) begin
         r = lim_hi;
      end else if (v < EXT_W'(lim_lo)) begin
         r = lim_lo;
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   assign lo = (cfg.lower_limit > cfg.upper_limit) ? cfg.upper_limit : cfg.lower_limit;
   assign hi = (cfg.lower_limit > cfg.upper_limit) ? cfg.lower_limit : cfg.upper_limit;

   assign cur      = clamp(EXT_W'(state.value), lo, hi);
   assign cur_ext  = EXT_W'(cur);
   assign step_ext = $signed({{(EXT_W-STEP_W){1'b0}}, cfg.step_size});
   assign sum_up   = cur_ext + step_ext;
   assign sum_dn   = cur_ext - step_ext;

   // gray order 00, 01, 11, 10
   assign pins     = {item.pin_a, item.pin_b};
   assign pos_new  = {pins[1], pins[1] ^ pins[0]};
   assign pos_old  = {state.last_pins[1], state.last_pins[1] ^ state.last_pins[0]};
   assign pos_diff = pos_new - pos_old;
   assign acc_step = (pos_diff == 2'd1) ? state.acc + ACC_W'(1) : state.acc - ACC_W'(1);

   always_comb begin
      state_nxt           = state;
      state_nxt.value     = cur;
      result.detent_event = EVT_NONE;
      result.invalid_move = 1'b0;
      if (item.req_type == REQ_LOAD) begin
         state_nxt.value = clamp(EXT_W'(item.load_value), lo, hi);
         state_nxt.acc   = '0;
      end else if (!state.primed) begin
         state_nxt.primed    = 1'b1;
         state_nxt.last_pins = pins;
      end else if (pins != state.last_pins) begin
         state_nxt.last_pins = pins;
         if (pos_diff == 2'd2) begin
            state_nxt.acc       = '0;
            result.invalid_move = 1'b1;
         end else if (acc_step >= DET_POS) begin
            state_nxt.acc       = '0;
            state_nxt.value     = clamp(sum_up, lo, hi);
            result.detent_event = EVT_UP;
         end else if (acc_step <= DET_NEG) begin
            state_nxt.acc       = '0;
            state_nxt.value     = clamp(sum_dn, lo, hi);
            result.detent_event = EVT_DOWN;
         end else begin
            state_nxt.acc = acc_step;
         end
      end
      result.current_value = state_nxt.value;
   end

endmodule

>>> hdl/quadrature_detent_value_tracker.sv
// Quadrature detent value tracker: x4 decoder, detent divider, clamped value.
// Path: a word goes from the input register to the result register, which drives rsp_valid.
// Throughput: one word per cycle while rsp_ready allows; a single update pass between them.
// Reset (synchronous): pins, prime flag, accumulator and value clear; limits and step reload.
// Depends on qdvt_pkg, qdvt_update and quadrature_detent_value_tracker_assert.svh.
`include "quadrature_detent_value_tracker_assert.svh"

module quadrature_detent_value_tracker #(
   parameter int unsigned MOVES_PER_DETENT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  qdvt_pkg::qdvt_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output qdvt_pkg::qdvt_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [qdvt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qdvt_pkg::VALUE_W-1:0]        csr_wdata
);
   import qdvt_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_BOUND = ACC_W'(MOVES_PER_DETENT);

   qdvt_cfg_type   cfg_ff, cfg_in;
   qdvt_state_type state_ff, state_in, state_nxt;
   qdvt_req_type   stg_ff, stg_in;
   logic           stg_vld_ff, stg_vld_in;
   qdvt_rsp_type   rsp_ff, rsp_in, result;
   logic           rsp_vld_ff, rsp_vld_in;
   logic           adv;
   logic           fire;
   logic           req_fire;
   logic           lim_wr;

   assign adv       = !rsp_vld_ff || rsp_ready;
   assign fire      = stg_vld_ff && adv;
   assign req_ready = !stg_vld_ff || adv;
   assign req_fire  = req_valid && req_ready;
   assign lim_wr    = csr_we && (csr_index == CSR_LOWER_LIMIT || csr_index == CSR_UPPER_LIMIT);

   qdvt_update #(
      .MOVES_PER_DETENT(MOVES_PER_DETENT)
   ) u_update (
      .item      (stg_ff),
      .state     (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_nxt),
      .result    (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOWER_LIMIT: cfg_in.lower_limit = $signed(csr_wdata);
            CSR_UPPER_LIMIT: cfg_in.upper_limit = $signed(csr_wdata);
            CSR_STEP_SIZE:   cfg_in.step_size   = csr_wdata[STEP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (fire) begin
         state_in = state_nxt;
      end
      if (lim_wr) begin
         state_in.acc = '0;
      end
   end

   assign stg_vld_in = req_fire ? 1'b1 : (fire ? 1'b0 : stg_vld_ff);
   assign stg_in     = req_fire ? req_data : stg_ff;
   assign rsp_vld_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
   assign rsp_in     = fire ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit <= LOWER_LIMIT_RST;
         cfg_ff.upper_limit <= UPPER_LIMIT_RST;
         cfg_ff.step_size   <= STEP_SIZE_RST;
         state_ff           <= '0;
         stg_vld_ff         <= 1'b0;
         rsp_vld_ff         <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         state_ff   <= state_in;
         stg_vld_ff <= stg_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `QDVT_ASSERT_NOW(a_acc_range, clock, reset, 1'b1, state_ff.acc < ACC_BOUND && state_ff.acc > -ACC_BOUND)
   `QDVT_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_vld_ff)
   `QDVT_ASSERT_NEXT(a_invalid_clears_acc, clock, reset, fire && result.invalid_move, state_ff.acc == '0)
   `QDVT_ASSERT_NOW(a_no_event_on_invalid, clock, reset, rsp_vld_ff && rsp_ff.invalid_move, rsp_ff.detent_event == EVT_NONE)

endmodule
